// File: src/gpc_pkg.sv
package gpc_pkg;

    localparam int ITER_W    = 32;
    localparam int POS_W     = 17;
    localparam int COLOR_W   = 24;
    localparam int SLOT_W    = 3;
    localparam int DENS_W    = 16;
    localparam int CNT_W     = 4;
    localparam int IN_DATA_W = 80;
    localparam int OUT_DATA_W = 24;

    // Width of the blend dividend and divisor.
    localparam int BX_W = 26;
    localparam int BD_W = 18;

    localparam logic [POS_W-1:0] POS_ONE = 17'h10000;

    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    localparam logic [1:0] REG_DENSITY = 2'd0;
    localparam logic [1:0] REG_PHASE   = 2'd1;
    localparam logic [1:0] REG_STOPS   = 2'd2;

    typedef struct packed {
        logic                 wr;
        logic                 interior;
        logic [SLOT_W-1:0]    slot;
        logic [POS_W-1:0]     pos;
        logic [COLOR_W-1:0]   rgb;
    } t_item;

endpackage

// File: src/gpc_phase.sv
module gpc_phase import gpc_pkg::*; #(
    parameter int PHASE_BITS = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  t_item                 i_item,
    input  logic [ITER_W-1:0]     i_iter,
    input  logic [DENS_W-1:0]     i_density,
    input  logic [DENS_W-1:0]     i_offset,
    output logic                  o_valid,
    output t_item                 o_item,
    output logic [PHASE_BITS-1:0] o_idx
);

    localparam int NW = ITER_W + 9;
    localparam int AW = NW - (16 - PHASE_BITS);

    logic              r_s0_valid;
    t_item             r_s0_item;
    logic [ITER_W-1:0] r_s0_iter;
    logic [31:0]       r_s0_prod;
    logic [NW-1:0]     w_n;

    logic [AW:0]           r_valid;
    t_item                 r_item [0:AW];
    logic [DENS_W-1:0]     r_rem  [0:AW];
    logic [AW-1:0]         r_a    [0:AW];
    logic [PHASE_BITS-1:0] r_q    [0:AW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (i_en) begin
            r_s0_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s0_item <= i_item;
            r_s0_iter <= i_iter;
            r_s0_prod <= i_offset * i_density;
        end
    end

    // Phase numerator: iter * 256 + offset * density.
    assign w_n = {1'b0, r_s0_iter, 8'b0} + {9'b0, r_s0_prod};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid[0] <= 1'b0;
        end else if (i_en) begin
            r_valid[0] <= r_s0_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item[0] <= r_s0_item;
            r_rem[0]  <= '0;
            r_a[0]    <= w_n[NW-1:16-PHASE_BITS];
            r_q[0]    <= '0;
        end
    end

    // Restoring division by density, one quotient bit per stage. Only the low
    // PHASE_BITS quotient bits are kept; they are the wrapped phase index.
    for (genvar k = 1; k <= AW; k++) begin : g_div
        logic [DENS_W:0] w_t;
        logic [DENS_W:0] w_diff;
        logic            w_ge;

        assign w_t    = {r_rem[k-1], r_a[k-1][AW-1]};
        assign w_ge   = w_t >= {1'b0, i_density};
        assign w_diff = w_t - {1'b0, i_density};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_en) begin
                r_valid[k] <= r_valid[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_item[k] <= r_item[k-1];
                r_rem[k]  <= w_ge ? w_diff[DENS_W-1:0] : w_t[DENS_W-1:0];
                r_a[k]    <= {r_a[k-1][AW-2:0], 1'b0};
                r_q[k]    <= {r_q[k-1][PHASE_BITS-2:0], w_ge};
            end
        end
    end

    assign o_valid = r_valid[AW];
    assign o_item  = r_item[AW];
    assign o_idx   = r_q[AW];

endmodule

// File: src/gpc_lookup.sv
module gpc_lookup import gpc_pkg::*; #(
    parameter int MAX_STOPS  = 8,
    parameter int PHASE_BITS = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  t_item                 i_item,
    input  logic [PHASE_BITS-1:0] i_idx,
    input  logic [CNT_W-1:0]      i_stop_count,
    output logic                  o_valid,
    output logic [2:0][BX_W-1:0]  o_x,
    output logic [BD_W-1:0]       o_d
);

    localparam logic [4:0] MS5 = 5'(MAX_STOPS);

    logic [POS_W-1:0]   r_pos [0:MAX_STOPS-1];
    logic [COLOR_W-1:0] r_rgb [0:MAX_STOPS-1];

    logic             w_wr;
    logic [POS_W-1:0] w_wpos;
    logic [POS_W-1:0] w_tq;
    logic [4:0]       w_used;
    logic [4:0]       w_jsel;
    logic             w_found;

    logic             r0_valid;
    logic             r0_interior;
    logic [POS_W-1:0] r0_tq;
    logic [4:0]       r0_jsel;

    logic [4:0]         w_cur;
    logic               w_has_next;
    logic [POS_W-1:0]   w_start;
    logic [POS_W-1:0]   w_end;
    logic [COLOR_W-1:0] w_a;
    logic [COLOR_W-1:0] w_b;

    logic               r1_valid;
    logic [COLOR_W-1:0] r1_a;
    logic [COLOR_W-1:0] r1_b;
    logic [POS_W-1:0]   r1_num;
    logic [POS_W-1:0]   r1_den;

    logic                r2_valid;
    logic [2:0][24:0]    r2_p0;
    logic [2:0][24:0]    r2_p1;
    logic [POS_W-1:0]    r2_den;

    logic                r3_valid;
    logic [2:0][BX_W-1:0] r3_x;
    logic [BD_W-1:0]     r3_d;

    // Stop writes take effect here, in item order with the pixels around them.
    assign w_wr = i_en && i_valid && (i_item.wr == ACT_WRITE)
                  && ({2'b0, i_item.slot} < MS5);

    always_comb begin
        w_wpos = (i_item.pos > POS_ONE) ? POS_ONE : i_item.pos;
        if (i_item.slot == '0) begin
            w_wpos = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int e = 0; e < MAX_STOPS; e++) begin
                r_pos[e] <= '0;
                r_rgb[e] <= '0;
            end
        end else begin
            for (int e = 0; e < MAX_STOPS; e++) begin
                if (w_wr && ({2'b0, i_item.slot} == 5'(e))) begin
                    r_pos[e] <= w_wpos;
                    r_rgb[e] <= i_item.rgb;
                end
            end
        end
    end

    // Segment search: first used slot above slot 0 whose position exceeds t.
    assign w_tq   = POS_W'(i_idx) << (16 - PHASE_BITS);
    assign w_used = {1'b0, i_stop_count};

    always_comb begin
        w_jsel  = MS5;
        w_found = 1'b0;
        for (int j = 1; j < MAX_STOPS; j++) begin
            if (!w_found && ((5'(j) >= w_used) || (r_pos[j] > w_tq))) begin
                w_jsel  = 5'(j);
                w_found = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
        end else if (i_en) begin
            r0_valid <= i_valid && (i_item.wr == ACT_PIXEL);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_interior <= i_item.interior;
            r0_tq       <= w_tq;
            r0_jsel     <= (w_jsel < w_used) ? w_jsel : w_used;
        end
    end

    assign w_cur      = r0_jsel - 5'd1;
    assign w_has_next = r0_jsel < w_used;

    always_comb begin
        w_start = '0;
        w_a     = '0;
        w_end   = POS_ONE;
        w_b     = r_rgb[0];
        for (int e = 0; e < MAX_STOPS; e++) begin
            if (5'(e) == w_cur) begin
                w_start = r_pos[e];
                w_a     = r_rgb[e];
            end
            if (w_has_next && (5'(e) == r0_jsel)) begin
                w_end = r_pos[e];
                w_b   = r_rgb[e];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= r0_valid;
        end
    end

    // A flat color (interior as black, empty segment, t before its start) runs through the blend as a/1.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r0_interior) begin
                r1_a   <= '0;
                r1_b   <= '0;
                r1_num <= '0;
                r1_den <= POS_W'(1);
            end else if ((w_end <= w_start) || (r0_tq < w_start)) begin
                r1_a   <= w_a;
                r1_b   <= w_a;
                r1_num <= '0;
                r1_den <= POS_W'(1);
            end else begin
                r1_a   <= w_a;
                r1_b   <= w_b;
                r1_num <= r0_tq - w_start;
                r1_den <= w_end - w_start;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else if (i_en) begin
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < 3; c++) begin
                r2_p0[c] <= r1_a[c*8 +: 8] * (r1_den - r1_num);
                r2_p1[c] <= r1_b[c*8 +: 8] * r1_num;
            end
            r2_den <= r1_den;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < 3; c++) begin
                r3_x[c] <= {r2_p0[c] + r2_p1[c], 1'b0} + BX_W'(r2_den);
            end
            r3_d <= {r2_den, 1'b0};
        end
    end

    assign o_valid = r3_valid;
    assign o_x     = r3_x;
    assign o_d     = r3_d;

endmodule

// File: src/gpc_blend.sv
module gpc_blend import gpc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [2:0][BX_W-1:0]  i_x,
    input  logic [BD_W-1:0]       i_d,
    output logic                  o_valid,
    output logic [COLOR_W-1:0]    o_rgb
);

    localparam int QB = 8;

    logic [QB:0]          r_valid;
    logic [2:0][BX_W-1:0] r_x [0:QB];
    logic [BD_W-1:0]      r_d [0:QB];
    logic [2:0][QB-1:0]   r_q [0:QB];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid[0] <= 1'b0;
        end else if (i_en) begin
            r_valid[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= i_x;
            r_d[0] <= i_d;
            r_q[0] <= '0;
        end
    end

    // Rounded quotient (2N + den) / (2 den), one bit per stage, MSB first.
    for (genvar k = 1; k <= QB; k++) begin : g_stage
        logic [BX_W-1:0] w_sub;

        assign w_sub = BX_W'(r_d[k-1]) << (QB - k);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_en) begin
                r_valid[k] <= r_valid[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_d[k] <= r_d[k-1];
                for (int c = 0; c < 3; c++) begin
                    if (r_x[k-1][c] >= w_sub) begin
                        r_x[k][c] <= r_x[k-1][c] - w_sub;
                        r_q[k][c] <= {r_q[k-1][c][QB-2:0], 1'b1};
                    end else begin
                        r_x[k][c] <= r_x[k-1][c];
                        r_q[k][c] <= {r_q[k-1][c][QB-2:0], 1'b0};
                    end
                end
            end
        end
    end

    assign o_valid = r_valid[QB];
    assign o_rgb   = {r_q[QB][2], r_q[QB][1], r_q[QB][0]};

endmodule

// File: src/gradient_palette_colorizer.sv
// Piecewise linear color gradient for fractal pixels.
// Input stream: tuser bit 0 selects the request kind (pixel or stop write),
// tuser bit 1 flags an interior pixel. A pixel request yields one RGB result
// on the output stream; a stop write yields none and updates the stop table
// in order with the pixels around it.
// Configuration registers (density, phase offset, stop count) are written
// through the plain write port while the block is idle; the user must keep to
// this, the block itself does not enforce it.
// Throughput is one request per cycle while the receiver does not stall. From
// input to result, the phase is found by a restoring divider with one quotient
// bit per stage (25 + PHASE_BITS stages), then four lookup stages, an 8-stage
// blend divider and the output register.
// Reset clears the stop table to black at position zero and loads density
// 256, phase offset 0 and stop count 1.
// When the receiver stalls, the whole pipeline holds and s_axis_tready drops;
// nothing is lost or repeated.
module gradient_palette_colorizer import gpc_pkg::*; #(
    parameter int MAX_STOPS  = 8,
    parameter int PHASE_BITS = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // smooth_iter, stop_slot, stop_position, stop_red, stop_green, stop_blue
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // action, interior
    input  logic [1:0]            s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // red, green, blue
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_index,
    input  logic [DENS_W-1:0]     i_cfg_data
);

    localparam logic [4:0] MS5 = 5'(MAX_STOPS);

    logic [DENS_W-1:0] r_density;
    logic [DENS_W-1:0] r_offset;
    logic [CNT_W-1:0]  r_stop_count;
    logic [CNT_W-1:0]  w_cnt;

    logic                  w_en;
    t_item                 w_item;
    logic                  w_ph_valid;
    t_item                 w_ph_item;
    logic [PHASE_BITS-1:0] w_ph_idx;
    logic                  w_lk_valid;
    logic [2:0][BX_W-1:0]  w_lk_x;
    logic [BD_W-1:0]       w_lk_d;
    logic                  w_bl_valid;
    logic [COLOR_W-1:0]    w_bl_rgb;

    logic                  r_out_valid;
    logic [COLOR_W-1:0]    r_out_rgb;

    always_comb begin
        w_cnt = i_cfg_data[CNT_W-1:0];
        if (w_cnt == '0) begin
            w_cnt = CNT_W'(1);
        end
        if ({1'b0, w_cnt} > MS5) begin
            w_cnt = MS5[CNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_density    <= DENS_W'(256);
            r_offset     <= '0;
            r_stop_count <= CNT_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_DENSITY: r_density <= (i_cfg_data == '0) ? DENS_W'(1) : i_cfg_data;
                REG_PHASE:   r_offset  <= i_cfg_data;
                REG_STOPS:   r_stop_count <= w_cnt;
                default: ;
            endcase
        end
    end

    assign w_en          = !r_out_valid || m_axis_tready;
    assign s_axis_tready = w_en;

    assign w_item.wr       = s_axis_tuser[0];
    assign w_item.interior = s_axis_tuser[1];
    assign w_item.slot     = s_axis_tdata[34:32];
    assign w_item.pos      = s_axis_tdata[51:35];
    assign w_item.rgb      = s_axis_tdata[75:52];

    gpc_phase #(
        .PHASE_BITS(PHASE_BITS)
    ) u_phase (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_valid   (s_axis_tvalid),
        .i_item    (w_item),
        .i_iter    (s_axis_tdata[ITER_W-1:0]),
        .i_density (r_density),
        .i_offset  (r_offset),
        .o_valid   (w_ph_valid),
        .o_item    (w_ph_item),
        .o_idx     (w_ph_idx)
    );

    gpc_lookup #(
        .MAX_STOPS (MAX_STOPS),
        .PHASE_BITS(PHASE_BITS)
    ) u_lookup (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (w_en),
        .i_valid      (w_ph_valid),
        .i_item       (w_ph_item),
        .i_idx        (w_ph_idx),
        .i_stop_count (r_stop_count),
        .o_valid      (w_lk_valid),
        .o_x          (w_lk_x),
        .o_d          (w_lk_d)
    );

    gpc_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_lk_valid),
        .i_x     (w_lk_x),
        .i_d     (w_lk_d),
        .o_valid (w_bl_valid),
        .o_rgb   (w_bl_rgb)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_bl_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_rgb <= w_bl_rgb;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_rgb;

    a_density_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_density != '0)
        else $error("density register holds zero");

    a_stop_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_stop_count != '0) && ({1'b0, r_stop_count} <= MS5))
        else $error("stop count out of range");

    a_ready_follows_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready does not track output register");

    a_stall_holds_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |=> (r_out_valid && $stable(r_out_rgb)))
        else $error("pending result changed during stall");

endmodule
